FILE: rtl/core/bir_pkg.sv
// Shared types and constants for the bilinear image resizer.
package bir_pkg;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int POS_W     = 12;
  localparam int CH_W      = 16;
  localparam int NCH       = 4;
  localparam int PIX_W     = CH_W * NCH;
  localparam int SDATA_W   = 2 * POS_W + PIX_W;
  localparam int MDATA_W   = PIX_W;
  localparam int DIM_W     = 13;
  localparam int SIZE_W    = 9;
  localparam int STEP_W    = 25;
  localparam int CFG_IDX_W = 3;

  localparam int FRAC_W  = 16;
  localparam int WGT_W   = FRAC_W + 1;
  localparam int WPROD_W = 2 * FRAC_W + 1;
  localparam int MAG_W   = 11;
  localparam int PROD_W  = MAG_W + WPROD_W;
  localparam int ACC_W   = 76;
  localparam int CHUNK_W = 19;

  localparam logic [CH_W-1:0] HALF_QNAN = 16'h7E00;
  localparam logic [CH_W-1:0] HALF_INF  = 16'h7C00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_HDR_MODE,
    REG_X_STEP,
    REG_Y_STEP
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD,
    OP_COMPUTE
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_READ,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_N4,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic hdr;
    logic clr;
    logic mul;
    logic acc;
    logic n1;
    logic n2;
    logic n3;
    logic n4;
  } lane_ctl_t;
endpackage

FILE: rtl/core/bir_ram.sv
// Generic single-port synchronous RAM with registered read.
module bir_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      else rdata <= mem[addr];
    end
  end
endmodule

FILE: rtl/core/bir_pos.sv
// Source sample position: neighbor indices clamped to the frame and Q16 fraction.
module bir_pos import bir_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_WIDTH,
  localparam int IW = $clog2(MAX_DIM)
) (
  input  logic              clk,
  input  logic              mul_en,
  input  logic              clamp_en,
  input  logic [POS_W-1:0]  dst,
  input  logic [STEP_W-1:0] step,
  input  logic [DIM_W-1:0]  dim,
  output logic [IW-1:0]     i0,
  output logic [IW-1:0]     i1,
  output logic [FRAC_W-1:0] frac
);
  localparam int P_W = POS_W + 1 + STEP_W;
  localparam int U_W = P_W - FRAC_W;

  logic [P_W-1:0] prod;
  logic [P_W:0]   sum;
  logic [P_W-1:0] u;
  logic [U_W-1:0] ui, top, base, nxt;

  always_ff @(posedge clk) begin
    if (mul_en) prod <= P_W'({dst, 1'b1}) * P_W'(step);
  end

  // u holds sx + 1 in Q16, so its integer part ui is floor(sx) + 1
  always_comb begin
    sum  = {1'b0, prod} + ((P_W+1)'(1) << FRAC_W);
    u    = sum[P_W:1];
    ui   = u[P_W-1:FRAC_W];
    top  = U_W'(dim) - U_W'(1);
    base = (ui == '0) ? '0 : ui - U_W'(1);
    if (base > top) base = top;
    nxt  = (ui > top) ? top : ui;
  end

  always_ff @(posedge clk) begin
    if (clamp_en) begin
      i0   <= base[IW-1:0];
      i1   <= nxt[IW-1:0];
      frac <= u[FRAC_W-1:0];
    end
  end
endmodule

FILE: rtl/core/bir_lane.sv
// One channel: sample decode, weight multiply and signed accumulate.
module bir_lane import bir_pkg::*; (
  input  logic               clk,
  input  lane_ctl_t          ctl,
  input  logic [CH_W-1:0]    sample,
  input  logic [WPROD_W-1:0] wgt,
  output logic [ACC_W-1:0]   acc,
  output logic               nonfin
);
  logic [4:0]        e;
  logic [MAG_W-1:0]  mag;
  logic [4:0]        sh;
  logic [PROD_W-1:0] prod;
  logic [4:0]        prod_sh;
  logic              prod_neg;
  logic [ACC_W-1:0]  term;

  always_comb begin
    e = sample[14:10];
    if (!ctl.hdr) begin
      mag = MAG_W'(sample[7:0]);
      sh  = '0;
    end else if (e == '0) begin
      mag = MAG_W'(sample[9:0]);
      sh  = '0;
    end else begin
      mag = {1'b1, sample[9:0]};
      sh  = e - 5'd1;
    end
    term = ACC_W'(prod) << prod_sh;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod     <= PROD_W'(mag) * PROD_W'(wgt);
      prod_sh  <= sh;
      prod_neg <= ctl.hdr & sample[15];
    end
    if (ctl.clr) begin
      acc    <= '0;
      nonfin <= 1'b0;
    end else begin
      if (ctl.acc) acc <= prod_neg ? acc - term : acc + term;
      if (ctl.mul && ctl.hdr && e == 5'h1F) nonfin <= 1'b1;
    end
  end
endmodule

FILE: rtl/core/bir_hcvt.sv
// Final rounding: byte round/clamp, or normalize and round to half nearest-even.
module bir_hcvt import bir_pkg::*; (
  input  logic             clk,
  input  lane_ctl_t        ctl,
  input  logic [ACC_W-1:0] acc,
  input  logic             nonfin,
  output logic [CH_W-1:0]  res
);
  localparam int NCHUNK = ACC_W / CHUNK_W;
  localparam int CI_W   = $clog2(NCHUNK);
  localparam int BI_W   = $clog2(CHUNK_W);
  localparam int P_W    = $clog2(ACC_W);

  logic [ACC_W-1:0]   mag;
  logic               neg;
  logic [CI_W-1:0]    chunk, chunk_c;
  logic               nz, nz_c;
  logic [5:0]         shift, shift_c;
  logic [CHUNK_W-1:0] csel;
  logic [BI_W-1:0]    bpos;
  logic [P_W-1:0]     p;
  logic [ACC_W-1:0]   qf, rmask, rem, halfb, q, sdr_f;
  logic               up;
  logic [CH_W-1:0]    qc, hres, sres;
  logic [CH_W:0]      enc;

  always_comb begin
    chunk_c = '0;
    nz_c    = |mag;
    for (int c = 0; c < NCHUNK; c++) begin
      if (|mag[c*CHUNK_W +: CHUNK_W]) chunk_c = CI_W'(c);
    end
    csel = mag[chunk*CHUNK_W +: CHUNK_W];
    bpos = '0;
    for (int b = 0; b < CHUNK_W; b++) begin
      if (csel[b]) bpos = BI_W'(b);
    end
    p = P_W'(chunk) * P_W'(CHUNK_W) + P_W'(bpos);
    if (p >= P_W'(42)) shift_c = (p - P_W'(10) > P_W'(63)) ? 6'd63 : 6'(p - P_W'(10));
    else shift_c = 6'd32;

    qf    = mag >> shift;
    rmask = (ACC_W'(1) << shift) - ACC_W'(1);
    rem   = mag & rmask;
    halfb = ACC_W'(1) << (shift - 6'd1);
    up    = (rem > halfb) || (rem == halfb && qf[0]);
    q     = qf + ACC_W'(up);
    qc    = (q > ACC_W'(HALF_INF)) ? HALF_INF : q[CH_W-1:0];
    enc   = (CH_W+1)'({shift - 6'd32, 10'b0}) + (CH_W+1)'(qc);
    if (enc > (CH_W+1)'(HALF_INF)) enc = (CH_W+1)'(HALF_INF);
    if (nonfin) hres = HALF_QNAN;
    else if (!nz) hres = '0;
    else hres = {neg, enc[CH_W-2:0]};

    sdr_f = (acc + (ACC_W'(1) << 31)) >> 32;
    sres  = (sdr_f > ACC_W'(255)) ? CH_W'(255) : CH_W'(sdr_f[7:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.n1) begin
      neg <= acc[ACC_W-1];
      mag <= acc[ACC_W-1] ? -acc : acc;
    end
    if (ctl.n2) begin
      chunk <= chunk_c;
      nz    <= nz_c;
    end
    if (ctl.n3) shift <= shift_c;
    if (ctl.n4) res <= ctl.hdr ? hres : sres;
  end
endmodule

FILE: rtl/core/bilinear_image_resize_top.sv
// Bilinear image resizer top level: config, frame store, read sequencer and output register.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser opcode, s_tdata position and pixel
//  m_*      out  m_tvalid/m_tready  m_tdata four result channels
//  cfg_*    in   cfg_wr             cfg_addr register, cfg_wdata value
//
// A load's frame store write happens at the accept edge.
// A compute goes from accept to a full output register through one clamp state,
// four reads of the single-port frame store plus the multiply/accumulate pipe,
// four rounding states (N1 to N4) and the output load. The store port sets the read phase.
// Reset is synchronous; the frame store is not cleared. A stalled output holds the
// next compute in its last state, and no input is taken while it waits there.
module bilinear_image_resize_top import bir_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [SDATA_W-1:0]   s_tdata,   // pos_x, pos_y, chan0, chan1, chan2, chan3
  input  logic                 s_tuser,   // opcode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [MDATA_W-1:0]   m_tdata,   // out_chan0, out_chan1, out_chan2, out_chan3
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [STEP_W-1:0]    cfg_wdata
);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  state_t              state, state_next;
  logic [2:0]          cnt;
  logic                rdv, mv, issue, pos_mul, pos_clamp, out_load;
  logic [SIZE_W-1:0]   src_width, src_height;
  logic                hdr_mode;
  logic [STEP_W-1:0]   x_step, y_step;
  logic [DIM_W-1:0]    eff_w, eff_h;
  logic [POS_W-1:0]    px, py;
  logic                load_ok;
  logic                ram_en, ram_we;
  logic [AW-1:0]       ram_addr;
  logic [PIX_W-1:0]    ram_rdata;
  logic [XW-1:0]       x0, x1, col;
  logic [YW-1:0]       y0, y1, row;
  logic [FRAC_W-1:0]   fx, fy;
  logic [WGT_W-1:0]    wx, wy;
  logic [WPROD_W-1:0]  wgt;
  lane_ctl_t           ctl;
  logic [CH_W-1:0]     res [NCH];

  assign px = s_tdata[POS_W-1:0];
  assign py = s_tdata[2*POS_W-1:POS_W];

  always_comb begin
    if (src_width == '0) eff_w = DIM_W'(1);
    else if (DIM_W'(src_width) > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
    else eff_w = DIM_W'(src_width);
    if (src_height == '0) eff_h = DIM_W'(1);
    else if (DIM_W'(src_height) > DIM_W'(MAX_HEIGHT)) eff_h = DIM_W'(MAX_HEIGHT);
    else eff_h = DIM_W'(src_height);
    load_ok = (opcode_t'(s_tuser) == OP_LOAD) && (DIM_W'(px) < eff_w)
              && (DIM_W'(py) < eff_h);
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    row        = cnt[1] ? y1 : y0;
    col        = cnt[0] ? x1 : x0;
    pos_mul    = 1'b0;
    pos_clamp  = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    ctl        = '0;
    ctl.hdr    = hdr_mode;
    ctl.mul    = rdv;
    ctl.acc    = mv;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (opcode_t'(s_tuser) == OP_COMPUTE) begin
            pos_mul    = 1'b1;
            state_next = ST_CLAMP;
          end else if (load_ok) begin
            ram_en = 1'b1;
            ram_we = 1'b1;
            row    = py[YW-1:0];
            col    = px[XW-1:0];
          end
        end
      end
      ST_CLAMP: begin
        pos_clamp  = 1'b1;
        ctl.clr    = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        issue  = !cnt[2];
        ram_en = issue;
        if (cnt == 3'd5) state_next = ST_N1;
      end
      ST_N1: begin
        ctl.n1     = 1'b1;
        state_next = ST_N2;
      end
      ST_N2: begin
        ctl.n2     = 1'b1;
        state_next = ST_N3;
      end
      ST_N3: begin
        ctl.n3     = 1'b1;
        state_next = ST_N4;
      end
      ST_N4: begin
        ctl.n4     = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign ram_addr = AW'(AW'(row) * AW'(MAX_WIDTH) + AW'(col));
  assign wx = cnt[0] ? WGT_W'(fx) : (WGT_W'(1) << FRAC_W) - WGT_W'(fx);
  assign wy = cnt[1] ? WGT_W'(fy) : (WGT_W'(1) << FRAC_W) - WGT_W'(fy);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      rdv        <= 1'b0;
      mv         <= 1'b0;
      m_tvalid   <= 1'b0;
      src_width  <= SIZE_W'(256);
      src_height <= SIZE_W'(256);
      hdr_mode   <= 1'b0;
      x_step     <= STEP_W'(65536);
      y_step     <= STEP_W'(65536);
    end else begin
      state <= state_next;
      cnt   <= (state == ST_READ) ? cnt + 3'd1 : '0;
      rdv   <= issue;
      mv    <= rdv;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_SRC_WIDTH:  src_width  <= cfg_wdata[SIZE_W-1:0];
          REG_SRC_HEIGHT: src_height <= cfg_wdata[SIZE_W-1:0];
          REG_HDR_MODE:   hdr_mode   <= cfg_wdata[0];
          REG_X_STEP:     x_step     <= cfg_wdata;
          REG_Y_STEP:     y_step     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) wgt <= WPROD_W'(wx) * WPROD_W'(wy);
    if (out_load) m_tdata <= {res[3], res[2], res[1], res[0]};
  end

  bir_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (s_tdata[SDATA_W-1:2*POS_W]),
    .rdata (ram_rdata)
  );

  bir_pos #(.MAX_DIM(MAX_WIDTH)) u_pos_x (
    .clk      (clk),
    .mul_en   (pos_mul),
    .clamp_en (pos_clamp),
    .dst      (px),
    .step     (x_step),
    .dim      (eff_w),
    .i0       (x0),
    .i1       (x1),
    .frac     (fx)
  );

  bir_pos #(.MAX_DIM(MAX_HEIGHT)) u_pos_y (
    .clk      (clk),
    .mul_en   (pos_mul),
    .clamp_en (pos_clamp),
    .dst      (py),
    .step     (y_step),
    .dim      (eff_h),
    .i0       (y0),
    .i1       (y1),
    .frac     (fy)
  );

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    logic [ACC_W-1:0] acc;
    logic             nonfin;

    bir_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .sample (ram_rdata[c*CH_W +: CH_W]),
      .wgt    (wgt),
      .acc    (acc),
      .nonfin (nonfin)
    );

    bir_hcvt u_hcvt (
      .clk    (clk),
      .ctl    (ctl),
      .acc    (acc),
      .nonfin (nonfin),
      .res    (res[c])
    );
  end
endmodule

FILE: rtl/core/bir_chk.sv
// Port-level checker for the resizer, bound to the top level.
module bir_chk import bir_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [SDATA_W-1:0]   s_tdata,
  input logic                 s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [MDATA_W-1:0]   m_tdata,
  input logic                 cfg_wr,
  input logic [CFG_IDX_W-1:0] cfg_addr,
  input logic [STEP_W-1:0]    cfg_wdata
);
  logic       hdr_q;
  logic [1:0] pend;
  logic       comp_acc, out_acc;

  assign comp_acc = s_tvalid && s_tready && (opcode_t'(s_tuser) == OP_COMPUTE);
  assign out_acc  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_q <= 1'b0;
      pend  <= '0;
    end else begin
      if (cfg_wr && cfg_reg_t'(cfg_addr) == REG_HDR_MODE) hdr_q <= cfg_wdata[0];
      pend <= pend + 2'(comp_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output request changed while stalled");

  a_out_has_src: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pend != 2'd0)
    else $error("output request without a pending compute");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    comp_acc |=> !s_tready)
    else $error("input ready right after a compute request");

  a_sdr_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !hdr_q |-> m_tdata[15:8] == 8'h00 && m_tdata[31:24] == 8'h00
                        && m_tdata[47:40] == 8'h00 && m_tdata[63:56] == 8'h00)
    else $error("byte mode result above 255");
endmodule

bind bilinear_image_resize_top bir_chk u_bir_chk (.*);

FILE: dv/testbench.sv
// Self-checking testbench for the bilinear image resizer: directed and random loads and computes.
module testbench import bir_pkg::*;;

  localparam int MW = DEF_MAX_WIDTH;
  localparam int MH = DEF_MAX_HEIGHT;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [SDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [MDATA_W-1:0] m_tdata;
  logic cfg_wr = 0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [STEP_W-1:0] cfg_wdata = '0;

  always #10 clk = ~clk;

  bilinear_image_resize_top u_dut (.*);

  // predictor state
  logic [PIX_W-1:0] pix_mem [MW*MH];
  logic [SIZE_W-1:0] width_reg, height_reg;
  logic hdr_reg;
  logic [STEP_W-1:0] xstep_reg, ystep_reg;

  logic [MDATA_W-1:0] pending_pixels [$];
  int send_idle_pct, recv_idle_pct;
  int mismatches, results_seen, loads_sent, computes_sent, hdr_computes;

  function automatic int eff_size(logic [SIZE_W-1:0] r, int lim);
    if (r == 0) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  function automatic void src_pos(int d, logic [STEP_W-1:0] step, int dim,
                                  output int i0, output int i1, output longint frac);
    longint u;
    longint b;
    u = ((2 * longint'(d) + 1) * longint'(step) + 65536) >>> 1;
    b = (u >>> 16) - 1;
    frac = u & 16'hFFFF;
    i0 = (b < 0) ? 0 : (b > dim - 1) ? dim - 1 : int'(b);
    i1 = (b + 1 > dim - 1) ? dim - 1 : int'(b + 1);
  endfunction

  // half bits to signed value in units of 2^-24
  function automatic longint half_fix(logic [15:0] h);
    longint mag;
    mag = (h[14:10] == 0) ? longint'(h[9:0]) :
          (longint'(1024 + h[9:0]) << (h[14:10] - 1));
    return h[15] ? -mag : mag;
  endfunction

  // signed value in units of 2^-56 to half, nearest-even
  function automatic logic [15:0] fix_half(logic signed [127:0] v);
    logic neg;
    logic [127:0] a, q, rem, hb;
    int p, sh;
    logic [31:0] enc;
    neg = v[127];
    a = neg ? -v : v;
    if (a == 0) return 16'h0000;
    p = 0;
    for (int i = 0; i < 128; i++) if (a[i]) p = i;
    sh = (p >= 42) ? p - 10 : 32;
    if (sh > 63) sh = 63;
    q = a >> sh;
    rem = a & ((128'd1 << sh) - 1);
    hb = 128'd1 << (sh - 1);
    if (rem > hb || (rem == hb && q[0])) q++;
    if (q > 128'h7C00) q = 128'h7C00;
    enc = ((sh - 32) << 10) + q[31:0];
    if (enc > 32'h7C00) enc = 32'h7C00;
    return {neg, 15'b0} | enc[15:0];
  endfunction

  function automatic logic [MDATA_W-1:0] resize_pixel(int dx, int dy);
    int w, h, x0, x1, y0, y1;
    longint fx, fy;
    logic [15:0] s [4];
    logic [MDATA_W-1:0] res;
    w = eff_size(width_reg, MW);
    h = eff_size(height_reg, MH);
    src_pos(dx, xstep_reg, w, x0, x1, fx);
    src_pos(dy, ystep_reg, h, y0, y1, fy);
    for (int c = 0; c < NCH; c++) begin
      s[0] = pix_mem[y0*MW + x0][c*16 +: 16];
      s[1] = pix_mem[y0*MW + x1][c*16 +: 16];
      s[2] = pix_mem[y1*MW + x0][c*16 +: 16];
      s[3] = pix_mem[y1*MW + x1][c*16 +: 16];
      if (hdr_reg) begin
        if (&s[0][14:10] || &s[1][14:10] || &s[2][14:10] || &s[3][14:10]) begin
          res[c*16 +: 16] = HALF_QNAN;
        end else begin
          logic signed [127:0] top, bot;
          top = half_fix(s[0]) * (65536 - fx) + half_fix(s[1]) * fx;
          bot = half_fix(s[2]) * (65536 - fx) + half_fix(s[3]) * fx;
          res[c*16 +: 16] = fix_half(top * (65536 - fy) + bot * fy);
        end
      end else begin
        logic [63:0] top, bot, v;
        top = s[0][7:0] * (65536 - fx) + s[1][7:0] * fx;
        bot = s[2][7:0] * (65536 - fx) + s[3][7:0] * fx;
        v = (top * (65536 - fy) + bot * fy + 64'h80000000) >> 32;
        res[c*16 +: 16] = (v > 255) ? 16'd255 : v[15:0];
      end
    end
    return res;
  endfunction

  task automatic send_request(opcode_t op, int px, int py, logic [PIX_W-1:0] pix);
    while (($urandom % 100) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {pix, py[11:0], px[11:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_LOAD) begin
      loads_sent++;
      if (px < eff_size(width_reg, MW) && py < eff_size(height_reg, MH)) begin
        pix_mem[py*MW + px] = pix;
      end
    end else begin
      computes_sent++;
      if (hdr_reg) hdr_computes++;
      pending_pixels.push_back(resize_pixel(px, py));
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int val);
    cfg_wr <= 1;
    cfg_addr <= idx;
    cfg_wdata <= STEP_W'(val);
    @(negedge clk);
    cfg_wr <= 0;
    case (idx)
      REG_SRC_WIDTH: width_reg = SIZE_W'(val);
      REG_SRC_HEIGHT: height_reg = SIZE_W'(val);
      REG_HDR_MODE: hdr_reg = val[0];
      REG_X_STEP: xstep_reg = STEP_W'(val);
      default: ystep_reg = STEP_W'(val);
    endcase
  endtask

  task automatic setup_frame(int w, int h, logic hdr, int xs, int ys);
    drain_results();
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_HDR_MODE, hdr);
    write_reg(REG_X_STEP, xs);
    write_reg(REG_Y_STEP, ys);
  endtask

  function automatic logic [15:0] rand_half();
    case ($urandom_range(0, 9))
      0: return {1'($urandom_range(0, 1)), 5'h1F, 10'($urandom)};
      1: return {1'($urandom_range(0, 1)), 5'h00, 10'($urandom)};
      2: return 16'h7BFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel(logic hdr);
    logic [PIX_W-1:0] p;
    for (int c = 0; c < NCH; c++)
      p[c*16 +: 16] = hdr ? rand_half() : 16'($urandom);
    return p;
  endfunction

  // fill the whole effective source frame
  task automatic load_frame();
    int w, h;
    w = eff_size(width_reg, MW);
    h = eff_size(height_reg, MH);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        send_request(OP_LOAD, x, y, rand_pixel(hdr_reg));
  endtask

  task automatic test_directed();
    setup_frame(2, 2, 0, 65536, 65536);
    send_request(OP_LOAD, 0, 0, {16'hFFFF, 16'h00FF, 16'h0000, 16'hFF00});
    send_request(OP_LOAD, 1, 0, {16'h0001, 16'h00FF, 16'hFFFF, 16'h0080});
    send_request(OP_LOAD, 0, 1, {16'h00FF, 16'h0000, 16'h1234, 16'h007F});
    send_request(OP_LOAD, 1, 1, {16'h0000, 16'hFFFF, 16'h00FF, 16'h0081});
    send_request(OP_LOAD, 4095, 4095, '1);
    send_request(OP_LOAD, 2, 0, '1);
    send_request(OP_COMPUTE, 0, 0, '0);
    send_request(OP_COMPUTE, 1, 1, '1);
    send_request(OP_COMPUTE, 4095, 4095, '0);
    setup_frame(2, 2, 0, 32768, 98304);
    send_request(OP_COMPUTE, 1, 2, '0);
    send_request(OP_COMPUTE, 0, 1, '0);
    setup_frame(2, 2, 0, 0, 0);
    send_request(OP_COMPUTE, 4095, 7, '0);
    setup_frame(0, 511, 1, 16777216, 1);
    send_request(OP_LOAD, 0, 0, {16'h7C00, 16'h8000, 16'h3C00, 16'h0001});
    send_request(OP_LOAD, 0, 1, {16'h0000, 16'h0000, 16'hBC00, 16'h0001});
    send_request(OP_COMPUTE, 0, 0, '0);
    send_request(OP_COMPUTE, 4095, 0, '0);
    setup_frame(1, 2, 1, 0, 40000);
    send_request(OP_LOAD, 0, 0, {16'h7BFF, 16'hFBFF, 16'h7E01, 16'h03FF});
    send_request(OP_LOAD, 0, 1, {16'h7BFF, 16'h7BFF, 16'h0000, 16'h8001});
    send_request(OP_COMPUTE, 0, 0, '0);
    send_request(OP_COMPUTE, 5, 0, '0);
  endtask

  task automatic random_phase(int nitems);
    int w, h, xs, ys, sent;
    sent = 0;
    while (sent < nitems) begin
      case ($urandom_range(0, 5))
        0: begin w = MW; h = $urandom_range(1, 3); end
        1: begin w = $urandom_range(1, 3); h = MH; end
        default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 12); end
      endcase
      case ($urandom_range(0, 4))
        0: xs = 0;
        1: xs = 16777216;
        2: xs = $urandom_range(0, 33554431);
        default: xs = $urandom_range(0, 262144);
      endcase
      ys = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 33554431)
                                       : $urandom_range(0, 262144);
      setup_frame(w, h, 1'($urandom_range(0, 1)), xs, ys);
      load_frame();
      sent += w * h;
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(OP_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       rand_pixel(hdr_reg));
        end else begin
          int dx, dy;
          dx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 30);
          dy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 30);
          send_request(OP_COMPUTE, dx, dy, rand_pixel(1));
        end
        sent++;
      end
      if ($urandom_range(0, 3) == 0) drain_results();
    end
  endtask

  task automatic test_random_with_stalls();
    send_idle_pct = 29; recv_idle_pct = 72;
    random_phase(600);
    send_idle_pct = 72; recv_idle_pct = 29;
    random_phase(600);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(600);
  endtask

  // output side
  always @(negedge clk)
    if (!rst) m_tready <= (($urandom % 100) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        logic [MDATA_W-1:0] exp_pix;
        exp_pix = pending_pixels.pop_front();
        for (int c = 0; c < NCH; c++)
          if (m_tdata[c*16 +: 16] !== exp_pix[c*16 +: 16]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d chan%0d: expected %h actual %h",
                       results_seen, c, exp_pix[c*16 +: 16], m_tdata[c*16 +: 16]);
          end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("bilinear_image_resize_top verification failed");
    $finish;
  end

  initial begin
    width_reg = 256; height_reg = 256; hdr_reg = 0;
    xstep_reg = 65536; ystep_reg = 65536;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_random_with_stalls();
    drain_results();
    if (pending_pixels.size() != 0) mismatches++;
    $display("%0d loads and %0d computes (%0d half-float), %0d results checked",
             loads_sent, computes_sent, hdr_computes, results_seen);
    if (mismatches == 0) begin
      $display("bilinear_image_resize_top verification clean");
    end else begin
      $display("bilinear_image_resize_top verification failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/bir_pkg.sv
rtl/core/bir_ram.sv
rtl/core/bir_pos.sv
rtl/core/bir_lane.sv
rtl/core/bir_hcvt.sv
rtl/core/bilinear_image_resize_top.sv
rtl/core/bir_chk.sv
dv/testbench.sv
